// ===== rtl/core/wve_pkg.sv =====
// Weighted vertex embedding: shared payload types and fixed-point constants.
// No dependencies; compiled first.
package wve_pkg;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_INFLUENCE = 1'b1;

    localparam int POS_W   = 32;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = POS_W + WGT_W;
    localparam int ACC_W   = 56;
    localparam int FRAC_SH = 14;
    localparam int VCNT_W  = 17;
    localparam int VIDX_W  = 16;

    localparam logic [VCNT_W-1:0] VCNT_MAX   = 17'h10000;
    localparam logic [ACC_W-1:0]  ROUND_BIAS = 56'd8192;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic                    cmd;
        logic [9:0]              node_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [WGT_W-1:0] weight;
        logic                    last_influence;
    } t_in_item;

    typedef struct packed {
        logic [VIDX_W-1:0]       vertex_index;
        logic signed [POS_W-1:0] vertex_x;
        logic signed [POS_W-1:0] vertex_y;
        logic signed [POS_W-1:0] vertex_z;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic [VCNT_W-1:0] vertex_count;
    } t_cfg_item;

endpackage

// ===== rtl/core/wve_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Payload types come from wve_pkg.
interface wve_chan_if #(parameter type t_payload = logic);

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/weighted_vertex_embedding_top.sv =====
// Weighted vertex embedding: node store, three multiply-accumulate lanes,
// rounding and saturation, output queue. Depends on wve_pkg and wve_chan_if.
//
// Usage:
//   i_in carries commands. A load writes one node position into the node
//   store; an influence reads a node, scales it by a Q2.14 weight and adds
//   it to the x/y/z accumulators. An influence flagged last emits one vertex
//   on o_out (Q16.16, rounded half up, saturated, with a clip flag) and
//   clears the accumulators. i_cfg sets the vertex count at which the output
//   vertex index wraps; write it only while the block is idle.
//   Throughput: one command per cycle while i_in.ready is high, back to back,
//   loads and influences mixed freely. Path: the last influence passes the
//   node read, multiply and accumulate registers; rounding feeds the queue
//   directly, and o_out.valid rises once the vertex is written to the queue.
//   The node store is a single-port-write, registered-read memory of
//   NODE_COUNT x 96 bits; it has no reset and holds nothing until loaded.
//   Reset clears the accumulators, vertex index and queue, sets the vertex
//   count to 65536 and holds i_in.ready and i_cfg.ready low.
//   Stall: results wait in an eight-entry queue. i_in.ready drops only when
//   eight results are queued or in flight; the pipeline itself never stops.
module weighted_vertex_embedding_top #(
    parameter int NODE_COUNT = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    wve_chan_if.sink        i_in,
    wve_chan_if.sink        i_cfg,
    wve_chan_if.source      o_out
);

    localparam int AW    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NODE_W = 3 * wve_pkg::POS_W;
    localparam int CNT_W = wve_pkg::FIFO_AW + 1;

    wve_pkg::t_in_item  in_item;
    wve_pkg::t_cfg_item cfg_item;
    logic               in_xfer;
    logic               out_xfer;
    logic               in_range;
    logic [AW-1:0]      addr;

    assign in_item  = i_in.payload;
    assign cfg_item = i_cfg.payload;
    assign in_xfer  = i_in.valid & i_in.ready;
    assign in_range = (32'(in_item.node_index) < NODE_COUNT);
    assign addr     = AW'(in_item.node_index);

    // node store
    logic [NODE_W-1:0] r_node_mem [NODE_COUNT];
    logic [NODE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (in_xfer && in_item.cmd == wve_pkg::CMD_LOAD && in_range) begin
            r_node_mem[addr] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
        end
        if (in_xfer && in_item.cmd == wve_pkg::CMD_INFLUENCE) begin
            r_rd_data <= r_node_mem[addr];
        end
    end

    // stage 1: node read
    logic                                r_s1_vld;
    logic                                r_s1_last;
    logic                                r_s1_in_range;
    logic signed [wve_pkg::WGT_W-1:0]    r_s1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_xfer && in_item.cmd == wve_pkg::CMD_INFLUENCE;
        end
        r_s1_last     <= in_item.last_influence;
        r_s1_in_range <= in_range;
        r_s1_w        <= in_item.weight;
    end

    // stage 2: multiply
    logic signed [wve_pkg::POS_W-1:0]  node_x, node_y, node_z;
    logic signed [wve_pkg::PROD_W-1:0] n_px, n_py, n_pz;
    logic signed [wve_pkg::PROD_W-1:0] r_px, r_py, r_pz;
    logic                              r_s2_vld;
    logic                              r_s2_last;

    assign node_x = r_rd_data[NODE_W-1 -: wve_pkg::POS_W];
    assign node_y = r_rd_data[2*wve_pkg::POS_W-1 -: wve_pkg::POS_W];
    assign node_z = r_rd_data[wve_pkg::POS_W-1:0];

    always_comb begin
        if (r_s1_in_range) begin
            n_px = node_x * r_s1_w;
            n_py = node_y * r_s1_w;
            n_pz = node_z * r_s1_w;
        end else begin
            n_px = '0;
            n_py = '0;
            n_pz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_last <= r_s1_last;
        r_px      <= n_px;
        r_py      <= n_py;
        r_pz      <= n_pz;
    end

    // stage 3: accumulate
    logic signed [wve_pkg::ACC_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic signed [wve_pkg::ACC_W-1:0] n_sum_x, n_sum_y, n_sum_z;
    logic signed [wve_pkg::ACC_W-1:0] r_fin_x, r_fin_y, r_fin_z;
    logic                             r_s3_vld;

    assign n_sum_x = r_sum_x + wve_pkg::ACC_W'(r_px);
    assign n_sum_y = r_sum_y + wve_pkg::ACC_W'(r_py);
    assign n_sum_z = r_sum_z + wve_pkg::ACC_W'(r_pz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_z  <= '0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld & r_s2_last;
            if (r_s2_vld) begin
                if (r_s2_last) begin
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_sum_z <= '0;
                end else begin
                    r_sum_x <= n_sum_x;
                    r_sum_y <= n_sum_y;
                    r_sum_z <= n_sum_z;
                end
            end
        end
        r_fin_x <= n_sum_x;
        r_fin_y <= n_sum_y;
        r_fin_z <= n_sum_z;
    end

    // stage 4: round, clip, queue
    function automatic logic [wve_pkg::POS_W:0] round_clip(
        input logic signed [wve_pkg::ACC_W-1:0] acc
    );
        logic [wve_pkg::ACC_W:0] v;
        logic [wve_pkg::ACC_W-wve_pkg::FRAC_SH-wve_pkg::POS_W+1:0] top;
        v   = {acc[wve_pkg::ACC_W-1], acc} + {1'b0, wve_pkg::ROUND_BIAS};
        top = v[wve_pkg::ACC_W : wve_pkg::FRAC_SH+wve_pkg::POS_W-1];
        if (top == '0 || top == '1) begin
            round_clip = {1'b0, v[wve_pkg::FRAC_SH+wve_pkg::POS_W-1 : wve_pkg::FRAC_SH]};
        end else if (v[wve_pkg::ACC_W]) begin
            round_clip = {1'b1, 1'b1, {(wve_pkg::POS_W-1){1'b0}}};
        end else begin
            round_clip = {1'b1, 1'b0, {(wve_pkg::POS_W-1){1'b1}}};
        end
    endfunction

    logic [wve_pkg::POS_W:0]    rc_x, rc_y, rc_z;
    wve_pkg::t_out_item         push_item;
    logic [wve_pkg::VCNT_W-1:0] limit;
    logic [wve_pkg::VCNT_W-1:0] nv_inc;
    logic [wve_pkg::VIDX_W-1:0] n_next_vertex;
    logic [wve_pkg::VIDX_W-1:0] r_next_vertex;
    logic [wve_pkg::VCNT_W-1:0] r_vertex_count;

    assign rc_x = round_clip(r_fin_x);
    assign rc_y = round_clip(r_fin_y);
    assign rc_z = round_clip(r_fin_z);

    always_comb begin
        push_item.vertex_index = r_next_vertex;
        push_item.vertex_x     = rc_x[wve_pkg::POS_W-1:0];
        push_item.vertex_y     = rc_y[wve_pkg::POS_W-1:0];
        push_item.vertex_z     = rc_z[wve_pkg::POS_W-1:0];
        push_item.saturated    = rc_x[wve_pkg::POS_W] | rc_y[wve_pkg::POS_W]
                               | rc_z[wve_pkg::POS_W];
    end

    always_comb begin
        if (r_vertex_count == '0 || r_vertex_count > wve_pkg::VCNT_MAX) begin
            limit = wve_pkg::VCNT_MAX;
        end else begin
            limit = r_vertex_count;
        end
        nv_inc = wve_pkg::VCNT_W'(r_next_vertex) + 1'b1;
        if (nv_inc >= limit) begin
            n_next_vertex = '0;
        end else begin
            n_next_vertex = nv_inc[wve_pkg::VIDX_W-1:0];
        end
    end

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vertex  <= '0;
            r_vertex_count <= wve_pkg::VCNT_MAX;
        end else begin
            if (r_s3_vld) begin
                r_next_vertex <= n_next_vertex;
            end
            if (i_cfg.valid) begin
                r_vertex_count <= cfg_item.vertex_count;
            end
        end
    end

    wve_pkg::t_out_item          r_fifo [wve_pkg::FIFO_DEPTH];
    logic [wve_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [wve_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]            r_fill;
    logic [CNT_W-1:0]            r_cnt;
    logic                        claim;

    assign out_xfer      = o_out.valid & o_out.ready;
    assign claim         = in_xfer && in_item.cmd == wve_pkg::CMD_INFLUENCE
                         && in_item.last_influence;
    assign i_in.ready    = i_rst_n && (r_cnt != CNT_W'(wve_pkg::FIFO_DEPTH));
    assign o_out.valid   = (r_fill != '0);
    assign o_out.payload = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_s3_vld) begin
            r_fifo[r_wr_ptr] <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s3_vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (r_s3_vld && !out_xfer) begin
                r_fill <= r_fill + 1'b1;
            end else if (!r_s3_vld && out_xfer) begin
                r_fill <= r_fill - 1'b1;
            end
            if (claim && !out_xfer) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!claim && out_xfer) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(wve_pkg::FIFO_DEPTH))
        else $error("result credit count exceeds queue depth");

    a_fill_le_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cnt)
        else $error("queue holds more results than were claimed");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (r_fill != CNT_W'(wve_pkg::FIFO_DEPTH) || out_xfer))
        else $error("push into full result queue");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_vld |-> (r_sum_x == '0 && r_sum_y == '0 && r_sum_z == '0))
        else $error("accumulators not cleared after emission");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_last) |=> r_s3_vld)
        else $error("last influence did not reach rounding stage");

endmodule

// ===== dv/weighted_vertex_embedding_top_tb.sv =====
// Testbench for weighted_vertex_embedding_top: node loads and influences go in, each
// emitted vertex is predicted here and checked field by field on the output channel.
// Depends on wve_pkg, wve_chan_if and the RTL top level.
module weighted_vertex_embedding_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES         = 1024;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 52;
    localparam int RND_W         = wve_pkg::ACC_W - wve_pkg::FRAC_SH + 1;

    localparam logic signed [RND_W-1:0] Q_MAX = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0] Q_MIN = RND_W'(-64'sd2147483648);
    localparam logic signed [wve_pkg::POS_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic signed [wve_pkg::POS_W-1:0] POS_MIN = 32'h8000_0000;

    logic clk = 1'b0;
    logic rst_n;

    wve_chan_if #(.t_payload(wve_pkg::t_in_item))  in_ch ();
    wve_chan_if #(.t_payload(wve_pkg::t_cfg_item)) cfg_ch ();
    wve_chan_if #(.t_payload(wve_pkg::t_out_item)) out_ch ();

    weighted_vertex_embedding_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    logic signed [wve_pkg::POS_W-1:0] node_x [NODES];
    logic signed [wve_pkg::POS_W-1:0] node_y [NODES];
    logic signed [wve_pkg::POS_W-1:0] node_z [NODES];
    bit                               node_loaded [NODES];
    int unsigned                      loaded_nodes [$];
    logic [wve_pkg::ACC_W-1:0]        sum_x = '0;
    logic [wve_pkg::ACC_W-1:0]        sum_y = '0;
    logic [wve_pkg::ACC_W-1:0]        sum_z = '0;
    logic [wve_pkg::VIDX_W-1:0]       vertex_ptr = '0;
    logic [wve_pkg::VCNT_W-1:0]       wrap_count = wve_pkg::VCNT_MAX;
    wve_pkg::t_out_item               vertex_q [$];

    int fail_count = 0;
    bit hold_req   = 1'b0;
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [wve_pkg::POS_W:0] round_clip(
        input logic [wve_pkg::ACC_W-1:0] acc
    );
        logic signed [wve_pkg::ACC_W:0] biased;
        logic signed [RND_W-1:0]        q;
        biased = $signed({acc[wve_pkg::ACC_W-1], acc});
        biased = biased + $signed({1'b0, wve_pkg::ROUND_BIAS});
        q = RND_W'(biased >>> wve_pkg::FRAC_SH);
        if (q > Q_MAX) begin
            return {1'b1, POS_MAX};
        end
        if (q < Q_MIN) begin
            return {1'b1, POS_MIN};
        end
        return {1'b0, q[wve_pkg::POS_W-1:0]};
    endfunction

    task automatic apply_command(input wve_pkg::t_in_item it);
        logic signed [wve_pkg::PROD_W-1:0] px, py, pz;
        logic [wve_pkg::POS_W:0]           rx, ry, rz;
        wve_pkg::t_out_item                v;
        int unsigned                       wrap_at;
        if (it.cmd == wve_pkg::CMD_LOAD) begin
            node_x[it.node_index] = it.pos_x;
            node_y[it.node_index] = it.pos_y;
            node_z[it.node_index] = it.pos_z;
            if (!node_loaded[it.node_index]) begin
                node_loaded[it.node_index] = 1'b1;
                loaded_nodes = {loaded_nodes, 32'(it.node_index)};
            end
            return;
        end
        px = $signed(node_x[it.node_index]) * $signed(it.weight);
        py = $signed(node_y[it.node_index]) * $signed(it.weight);
        pz = $signed(node_z[it.node_index]) * $signed(it.weight);
        sum_x = sum_x + {{(wve_pkg::ACC_W-wve_pkg::PROD_W){px[wve_pkg::PROD_W-1]}}, px};
        sum_y = sum_y + {{(wve_pkg::ACC_W-wve_pkg::PROD_W){py[wve_pkg::PROD_W-1]}}, py};
        sum_z = sum_z + {{(wve_pkg::ACC_W-wve_pkg::PROD_W){pz[wve_pkg::PROD_W-1]}}, pz};
        if (!it.last_influence) begin
            return;
        end
        rx = round_clip(sum_x);
        ry = round_clip(sum_y);
        rz = round_clip(sum_z);
        v.vertex_index = vertex_ptr;
        v.vertex_x     = rx[wve_pkg::POS_W-1:0];
        v.vertex_y     = ry[wve_pkg::POS_W-1:0];
        v.vertex_z     = rz[wve_pkg::POS_W-1:0];
        v.saturated    = rx[wve_pkg::POS_W] | ry[wve_pkg::POS_W] | rz[wve_pkg::POS_W];
        vertex_q = {vertex_q, v};
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        if (wrap_count == '0 || wrap_count > wve_pkg::VCNT_MAX) begin
            wrap_at = 32'(wve_pkg::VCNT_MAX);
        end else begin
            wrap_at = 32'(wrap_count);
        end
        if (32'(vertex_ptr) + 1 >= wrap_at) begin
            vertex_ptr = '0;
        end else begin
            vertex_ptr = vertex_ptr + 1'b1;
        end
    endtask

    function automatic logic [wve_pkg::POS_W-1:0] rand_pos();
        logic [19:0] r;
        r = 20'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            return $urandom;
        end
        return {{(wve_pkg::POS_W-20){r[19]}}, r};
    endfunction

    function automatic logic [wve_pkg::WGT_W-1:0] rand_weight();
        logic [11:0] r;
        r = 12'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            return 16'($urandom);
        end
        return {{(wve_pkg::WGT_W-12){r[11]}}, r};
    endfunction

    function automatic wve_pkg::t_in_item make_load(input int unsigned idx,
                                                    input logic [wve_pkg::POS_W-1:0] x, y, z,
                                                    input logic last);
        wve_pkg::t_in_item it;
        it.cmd            = wve_pkg::CMD_LOAD;
        it.node_index     = idx[9:0];
        it.pos_x          = x;
        it.pos_y          = y;
        it.pos_z          = z;
        it.weight         = 16'($urandom);
        it.last_influence = last;
        return it;
    endfunction

    function automatic wve_pkg::t_in_item make_influence(input int unsigned idx,
                                                         input logic [wve_pkg::WGT_W-1:0] w,
                                                         input logic last);
        wve_pkg::t_in_item it;
        it.cmd            = wve_pkg::CMD_INFLUENCE;
        it.node_index     = idx[9:0];
        it.pos_x          = $urandom;
        it.pos_y          = $urandom;
        it.pos_z          = $urandom;
        it.weight         = w;
        it.last_influence = last;
        return it;
    endfunction

    function automatic int unsigned pick_node();
        return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
    endfunction

    task automatic send_cmd(input wve_pkg::t_in_item it);
        int gap;
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        apply_command(it);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(0, 3);
                if (gap > 0) begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [wve_pkg::VCNT_W-1:0] count);
        wve_pkg::t_cfg_item c;
        c.vertex_count = count;
        settle();
        cfg_ch.payload <= c;
        cfg_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        wrap_count = count;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_directed();
        send_cmd(make_load(0, 32'sd1, -32'sd1, 32'sd0, 1'b1));
        send_cmd(make_load(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000, 1'b0));
        send_cmd(make_load(512, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_8000, 1'b0));
        send_cmd(make_influence(0, 16'sd8192, 1'b1));
        send_cmd(make_influence(512, 16'sd8193, 1'b1));
        send_cmd(make_influence(512, 16'sd8192, 1'b1));
        send_cmd(make_influence(1023, 16'h7FFF, 1'b1));
        send_cmd(make_influence(1023, 16'h8000, 1'b1));
        send_cmd(make_influence(1023, 16'h4000, 1'b1));
        send_cmd(make_influence(0, 16'h0000, 1'b0));
        send_cmd(make_influence(1023, 16'h0001, 1'b0));
        send_cmd(make_influence(512, 16'hFFFF, 1'b0));
        send_cmd(make_load(1, rand_pos(), rand_pos(), rand_pos(), 1'b1));
        send_cmd(make_influence(1, 16'h4000, 1'b1));
        send_cmd(make_load(682, 32'hAAAA_AAAA, 32'h5555_5555, 32'hDEAD_BEEF, 1'b0));
        send_cmd(make_influence(682, 16'hAAAA, 1'b0));
        send_cmd(make_influence(682, 16'h5555, 1'b1));
        send_cmd(make_load(341, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0));
        send_cmd(make_influence(341, 16'hC000, 1'b1));
        settle();
    endtask

    task automatic test_index_wrap();
        write_vertex_count(17'd4);
        repeat (6) send_cmd(make_influence(pick_node(), rand_weight(), 1'b1));
        write_vertex_count(17'd1);
        repeat (3) send_cmd(make_influence(pick_node(), rand_weight(), 1'b1));
        write_vertex_count(17'd0);
        repeat (2) send_cmd(make_influence(pick_node(), rand_weight(), 1'b1));
        settle();
    endtask

    task automatic test_accumulator_wrap();
        int unsigned node;
        node = $urandom_range(0, NODES - 1);
        send_cmd(make_load(node, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        for (int i = 0; i < 559; i++) begin
            send_cmd(make_influence(node, 16'(32768 + $urandom_range(0, 768)), i == 558));
        end
        settle();
    endtask

    task automatic test_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (24) send_cmd(make_influence(pick_node(), rand_weight(), 1'b1));
        gaps_on = 1'b1;
        settle();
    endtask

    task automatic send_random_group(output int n);
        int k;
        n = 0;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    send_cmd(make_load($urandom_range(0, NODES - 1), rand_pos(), rand_pos(),
                                       rand_pos(), 1'b1));
                end
                1: begin
                    send_cmd(make_influence(pick_node(), rand_weight(), 1'b0));
                end
                default: begin
                    send_cmd(make_load($urandom_range(0, NODES - 1), rand_pos(), rand_pos(),
                                       rand_pos(), 1'b0));
                end
            endcase
            n = 1;
            return;
        end
        k = $urandom_range(0, 2);
        repeat (k) begin
            send_cmd(make_load($urandom_range(0, NODES - 1), rand_pos(), rand_pos(),
                               rand_pos(), 1'($urandom)));
        end
        n = k;
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
            send_cmd(make_influence(pick_node(), rand_weight(), i == k - 1));
        end
        n += k;
    endtask

    task automatic test_random();
        logic [wve_pkg::VCNT_W-1:0] count;
        int                         sent;
        int                         n;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: count = wve_pkg::VCNT_MAX;
                1: count = 17'h1FFFF;
                2: count = 17'd3;
                3: count = 17'd1;
                4: count = 17'h10001;
                5: count = 17'($urandom_range(5, 40));
                6: count = 17'd2;
                default: count = 17'd0;
            endcase
            write_vertex_count(count);
            gaps_on = (ph != 3);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                send_random_group(n);
                sent += n;
            end
        end
        gaps_on = 1'b1;
        settle();
    endtask

    always @(posedge clk) begin : out_check
        wve_pkg::t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (vertex_q.size() == 0) begin
                $error("vertex %0d transferred with no vertex expected",
                       out_ch.payload.vertex_index);
                fail_count++;
            end else begin
                want = vertex_q.pop_front();
                check_field("vertex_index", want.vertex_index, out_ch.payload.vertex_index);
                check_field("vertex_x", want.vertex_x, out_ch.payload.vertex_x);
                check_field("vertex_y", want.vertex_y, out_ch.payload.vertex_y);
                check_field("vertex_z", want.vertex_z, out_ch.payload.vertex_z);
                check_field("saturated", want.saturated, out_ch.payload.saturated);
            end
        end
    end

    initial begin : out_sink
        int mode;
        int mode_left;
        int held;
        mode      = 0;
        mode_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge clk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (mode_left % 8 < 5);
                endcase
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.payload  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_index_wrap();
        test_accumulator_wrap();
        test_backpressure();
        test_random();
        settle();
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/wve_pkg.sv
rtl/core/wve_chan_if.sv
rtl/core/weighted_vertex_embedding_top.sv
dv/weighted_vertex_embedding_top_tb.sv
